FILE: rtl/stsc_pkg.sv
// Shared types and constants for the stage timing sample collector.
`timescale 1ns / 1ps
package stsc_pkg;

  localparam int unsigned FrameW   = 64;
  localparam int unsigned StageW   = 4;
  localparam int unsigned DurW     = 32;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned TotalW   = 35;
  localparam int unsigned CountW   = 32;
  localparam int unsigned DoneW    = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Store geometry and stage layout.
  localparam int unsigned MaxFrames     = 1024;
  localparam int unsigned StageCount    = 13;
  localparam int unsigned EnvelopeStage = 12;
  localparam int unsigned SlotW         = 10;

  localparam logic [StatusW-1:0] StAccepted   = 4'd0;
  localparam logic [StatusW-1:0] StCompleted  = 4'd1;
  localparam logic [StatusW-1:0] StBadStage   = 4'd2;
  localparam logic [StatusW-1:0] StBadDur     = 4'd3;
  localparam logic [StatusW-1:0] StOutside    = 4'd4;
  localparam logic [StatusW-1:0] StWarmup     = 4'd5;
  localparam logic [StatusW-1:0] StUnrequired = 4'd6;
  localparam logic [StatusW-1:0] StDuplicate  = 4'd7;
  localparam logic [StatusW-1:0] StBadConfig  = 4'd8;

  localparam logic [CfgIdxW-1:0] RegFirstFrame    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWarmupFrames  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMeasured      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRequiredMask  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSummedMask    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegProducerMask  = 3'd5;

  // Category counter slots.
  localparam int unsigned NumCat = 6;
  localparam logic [2:0] CatBadStage   = 3'd0;
  localparam logic [2:0] CatBadDur     = 3'd1;
  localparam logic [2:0] CatOutside    = 3'd2;
  localparam logic [2:0] CatWarmup     = 3'd3;
  localparam logic [2:0] CatUnrequired = 3'd4;
  localparam logic [2:0] CatDuplicate  = 3'd5;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [2:0]         cat;
    logic               has_cat;
  } class_t;

endpackage

FILE: rtl/stsc_front.sv
// Front end: holds configuration and classifies each sample.
`timescale 1ns / 1ps
module stsc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stsc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [stsc_pkg::FrameW-1:0]    frame_i,
  input  logic [stsc_pkg::StageW-1:0]    stage_i,
  input  logic [stsc_pkg::DurW-1:0]      dur_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output stsc_pkg::class_t               q_class_o,
  output logic [stsc_pkg::SlotW-1:0]     q_slot_o,
  output logic [stsc_pkg::StageW-1:0]    q_stage_o,
  output logic [stsc_pkg::DurW-2:0]      q_dur_o,
  output logic [stsc_pkg::StageCount-1:0] req_mask_o,
  output logic [stsc_pkg::StageCount-1:0] sum_mask_o,
  output logic [stsc_pkg::StageCount-1:0] prod_mask_o
);
  import stsc_pkg::*;

  localparam int unsigned MeasW = 11;

  logic [FrameW-1:0]      first_q;
  logic [31:0]            warm_q;
  logic [MeasW-1:0]       meas_q;
  logic [12:0]            req_q, sum_q, prod_q;
  logic [FrameW:0]        wstart_sum;
  logic [FrameW-1:0]      wstart_q;
  logic                   ok_q;
  logic                   ovf_q;
  logic [1:0]             settle_q;

  // Configuration registers; derived window start is registered too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      warm_q  <= '0;
      meas_q  <= MeasW'(1);
      req_q   <= 13'h1FFF;
      sum_q   <= '0;
      prod_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFirstFrame:   first_q <= cfg_data_i;
        RegWarmupFrames: warm_q  <= cfg_data_i[31:0];
        RegMeasured:     meas_q  <= cfg_data_i[MeasW-1:0];
        RegRequiredMask: req_q   <= cfg_data_i[12:0];
        RegSummedMask:   sum_q   <= cfg_data_i[12:0];
        RegProducerMask: prod_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign wstart_sum = {1'b0, first_q} + {{(FrameW-31){1'b0}}, warm_q};

  // The last-frame check works on the registered window start, so the
  // validity flag settles only after that register has taken the new value.
  logic [FrameW:0] last_sum;
  logic            ok_d;
  logic [12:0]     bad_bits;
  assign bad_bits = ~13'((1 << StageCount) - 1);
  assign last_sum = {1'b0, wstart_q}
                  + {{(FrameW-MeasW+1){1'b0}}, meas_q - MeasW'(1)};
  always_comb begin
    ok_d = 1'b1;
    if (meas_q == '0 || meas_q > MeasW'(MaxFrames)) ok_d = 1'b0;
    if (req_q == '0 || (req_q & bad_bits) != '0) ok_d = 1'b0;
    if ((sum_q & bad_bits) != '0 || (prod_q & bad_bits) != '0) ok_d = 1'b0;
    if (ovf_q) ok_d = 1'b0;
    if (ok_d && last_sum[FrameW]) ok_d = 1'b0;
  end

  // Derived values; the input is held off until they have settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wstart_q <= '0;
      ok_q     <= 1'b1;
      ovf_q    <= 1'b0;
      settle_q <= '0;
    end else begin
      wstart_q <= wstart_sum[FrameW-1:0];
      ok_q     <= ok_d;
      ovf_q    <= wstart_sum[FrameW];
      if (cfg_we_i) begin
        settle_q <= 2'd2;
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  assign req_mask_o  = req_q[StageCount-1:0];
  assign sum_mask_o  = sum_q[StageCount-1:0];
  assign prod_mask_o = prod_q[StageCount-1:0];

  // Classification of the incoming sample.
  logic [FrameW-1:0] off;
  class_t            cls;
  assign off = frame_i - wstart_q;
  always_comb begin
    cls = '{status: StAccepted, cat: CatBadStage, has_cat: 1'b0};
    if (!ok_q) begin
      cls.status = StBadConfig;
    end else if (stage_i >= StageW'(StageCount)) begin
      cls = '{status: StBadStage, cat: CatBadStage, has_cat: 1'b1};
    end else if (dur_i[DurW-1]) begin
      cls = '{status: StBadDur, cat: CatBadDur, has_cat: 1'b1};
    end else if (frame_i < first_q) begin
      cls = '{status: StOutside, cat: CatOutside, has_cat: 1'b1};
    end else if (frame_i < wstart_q) begin
      cls = '{status: StWarmup, cat: CatWarmup, has_cat: 1'b1};
    end else if (off >= {{(FrameW-MeasW){1'b0}}, meas_q}) begin
      cls = '{status: StOutside, cat: CatOutside, has_cat: 1'b1};
    end
  end

  // One-entry queue register toward the back end.
  assign in_ready_o = (!q_valid_o || q_ready_i) && settle_q == '0 && !cfg_we_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_o <= 1'b0;
    end else if (!q_valid_o || q_ready_i) begin
      q_valid_o <= in_valid_i && in_ready_o;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      q_class_o <= cls;
      q_slot_o  <= off[SlotW-1:0];
      q_stage_o <= stage_i;
      q_dur_o   <= dur_i[DurW-2:0];
    end
  end

  ovf_known_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> !ok_q) else $error("window overflow with valid config");
  cfg_flag_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && q_class_o.status == StBadConfig) |-> !q_class_o.has_cat)
    else $error("bad config counted");
  hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && !q_ready_i) |=> q_valid_o) else $error("queue dropped item");

endmodule

FILE: rtl/stsc_back.sv
// Back end: merges samples into frame entries and counts categories.
`timescale 1ns / 1ps
module stsc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  stsc_pkg::class_t                q_class_i,
  input  logic [stsc_pkg::SlotW-1:0]      q_slot_i,
  input  logic [stsc_pkg::StageW-1:0]     q_stage_i,
  input  logic [stsc_pkg::DurW-2:0]       q_dur_i,
  input  logic [stsc_pkg::StageCount-1:0] req_mask_i,
  input  logic [stsc_pkg::StageCount-1:0] sum_mask_i,
  input  logic [stsc_pkg::StageCount-1:0] prod_mask_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stsc_pkg::StatusW-1:0]    status_o,
  output logic [stsc_pkg::SlotW-1:0]      slot_o,
  output logic [stsc_pkg::TotalW-1:0]     summed_o,
  output logic [stsc_pkg::TotalW-1:0]     producer_o,
  output logic [stsc_pkg::TotalW-1:0]     effect_o,
  output logic [stsc_pkg::DoneW-1:0]      done_o,
  output logic [stsc_pkg::CountW-1:0]     count_o
);
  import stsc_pkg::*;

  localparam int unsigned EntryW = StageCount + 3 * TotalW;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_e;

  // Entry memory: received mask, summed, producer, effect.
  logic [EntryW-1:0] mem [MaxFrames];
  logic [EntryW-1:0] rd_q;
  logic              we;
  logic [SlotW-1:0]  waddr;
  logic [SlotW-1:0]  raddr;
  logic [EntryW-1:0] wdata;

  state_e              state_q;
  logic [SlotW:0]      clr_q;
  logic [CountW-1:0]   cnt_q [NumCat];
  logic [DoneW-1:0]    done_q;
  class_t              cls_q;
  logic [SlotW-1:0]    slot_q;
  logic [StageW-1:0]   stage_q;
  logic [DurW-2:0]     dur_q;
  logic                fire;

  // The read address follows the held sample once it has been taken.
  assign raddr = (state_q == S_IDLE) ? q_slot_i : slot_q;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Unpack the read entry.
  logic [StageCount-1:0] rmask;
  logic [TotalW-1:0]     rsum, rprod, reff;
  assign rmask = rd_q[EntryW-1 -: StageCount];
  assign rsum  = rd_q[3*TotalW-1 -: TotalW];
  assign rprod = rd_q[2*TotalW-1 -: TotalW];
  assign reff  = rd_q[TotalW-1:0];

  // Merge arithmetic.
  logic [StageCount-1:0] bit_s, nmask;
  logic [TotalW-1:0]     durx, nsum, nprod, neff;
  logic                  unreq, dup;
  always_comb begin
    bit_s = StageCount'(1) << stage_q;
    durx  = {{(TotalW-DurW+1){1'b0}}, dur_q};
    unreq = (req_mask_i & bit_s) == '0;
    dup   = (rmask & bit_s) != '0;
    nmask = rmask | bit_s;
    nsum  = rsum + (((sum_mask_i & req_mask_i & bit_s) != '0) ? durx : '0);
    nprod = rprod + (((prod_mask_i & req_mask_i & bit_s) != '0) ? durx : '0);
    if (stage_q == StageW'(EnvelopeStage)) neff = durx;
    else if (rmask[EnvelopeStage]) neff = reff;
    else neff = nsum;
  end

  // Result of the held sample.
  logic [StatusW-1:0] r_status;
  logic [SlotW-1:0]   r_slot;
  logic [TotalW-1:0]  r_sum, r_prod, r_eff;
  logic [2:0]         r_cat;
  logic               r_bump;
  logic               r_done_inc;
  logic [CountW-1:0]  r_cnt;
  always_comb begin
    r_status   = cls_q.status;
    r_cat      = cls_q.cat;
    r_bump     = cls_q.has_cat;
    r_slot     = '0;
    r_sum      = '0;
    r_prod     = '0;
    r_eff      = '0;
    r_done_inc = 1'b0;
    if (cls_q.status == StAccepted) begin
      r_slot = slot_q;
      if (unreq || dup) begin
        r_cat    = unreq ? CatUnrequired : CatDuplicate;
        r_bump   = 1'b1;
        r_status = unreq ? StUnrequired : StDuplicate;
        r_sum    = rsum;
        r_prod   = rprod;
        r_eff    = reff;
      end else begin
        r_sum  = nsum;
        r_prod = nprod;
        r_eff  = neff;
        if (nmask == req_mask_i) begin
          r_status   = StCompleted;
          r_done_inc = done_q != '1;
        end
      end
    end
    r_cnt = (cnt_q[r_cat] != '1) ? cnt_q[r_cat] + 1'b1 : cnt_q[r_cat];
  end

  assign fire = state_q == S_WRITE && !clear_i && (!out_valid_o || out_ready_i);

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = {nmask, nsum, nprod, neff};
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q[SlotW-1:0];
      wdata = '0;
    end else if (fire && cls_q.status == StAccepted && !unreq && !dup) begin
      we = 1'b1;
    end
  end

  assign q_ready_o = state_q == S_IDLE && !clear_i;
  assign busy_o    = state_q != S_IDLE || out_valid_o || q_valid_i;

  // Sequencer: clear sweep, read, then write and report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      done_q      <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < NumCat; i++) cnt_q[i] <= '0;
    end else begin
      if (fire) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (clear_i) begin
        state_q <= S_CLEAR;
        clr_q   <= '0;
        done_q  <= '0;
        for (int i = 0; i < NumCat; i++) cnt_q[i] <= '0;
      end else begin
        case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + 1'b1;
            if (clr_q == (SlotW+1)'(MaxFrames - 1)) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (q_valid_i) state_q <= S_READ;
          end
          S_READ: state_q <= S_WRITE;
          S_WRITE: begin
            if (fire) begin
              if (r_done_inc) done_q <= done_q + 1'b1;
              if (r_bump) cnt_q[r_cat] <= r_cnt;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  // Sample capture and result register.
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      cls_q   <= q_class_i;
      slot_q  <= q_slot_i;
      stage_q <= q_stage_i;
      dur_q   <= q_dur_i;
    end
    if (fire) begin
      status_o   <= r_status;
      slot_o     <= r_slot;
      summed_o   <= r_sum;
      producer_o <= r_prod;
      effect_o   <= r_eff;
      done_o     <= r_done_inc ? done_q + 1'b1 : done_q;
      count_o    <= r_bump ? r_cnt : '0;
    end
  end

  clear_done_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == S_CLEAR && state_q == S_IDLE |-> clr_q == (SlotW+1)'(MaxFrames))
    else $error("clear sweep ended early");
  no_take_clear_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !q_ready_o) else $error("item taken during clear");
  write_phase_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q != S_CLEAR) |-> state_q == S_WRITE)
    else $error("entry written outside write phase");

endmodule

FILE: rtl/stage_timing_sample_collector.sv
// Top level of the stage timing sample collector.
`timescale 1ns / 1ps
// A result is presented after its sample passes these steps in order: the front
// classifies the sample into its register, the back sequencer takes it and
// reads the frame entry, reads it again in its read state, then merges, writes back
// and registers the result in one step around the entry memory. The back takes
// no new sample until it has finished the last one, passing through its idle, read
// and write states for each; a stalled result holds the back in its write step,
// and once the front register is also full the input stalls. After reset and after
// every write to a defined configuration register the entry memory is swept before
// samples are merged, and the input is held off after any write while the window settles.
module stage_timing_sample_collector (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // frame_number[63:0], stage_index[67:64], duration[99:68], zero fill
  input  logic [103:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[3:0], frame_slot[13:4], summed_total[48:14], producer_total[83:49],
  // effect_total[118:84], completed_frames[129:119], category_count[161:130]
  output logic [167:0]  m_axis_tdata
);
  import stsc_pkg::*;

  logic                   qv, qr, busy;
  class_t                 qc;
  logic [SlotW-1:0]       qs;
  logic [StageW-1:0]      qst;
  logic [DurW-2:0]        qd;
  logic [StageCount-1:0]  rm, sm, pm;
  logic [StatusW-1:0]     status;
  logic [SlotW-1:0]       slot;
  logic [TotalW-1:0]      st, pt, et;
  logic [DoneW-1:0]       done;
  logic [CountW-1:0]      cnt;
  logic                   clear;

  assign clear = cfg_we_i && cfg_idx_i <= RegProducerMask;

  stsc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .frame_i(s_axis_tdata[63:0]), .stage_i(s_axis_tdata[67:64]),
    .dur_i(s_axis_tdata[99:68]),
    .q_valid_o(qv), .q_ready_i(qr), .q_class_o(qc), .q_slot_o(qs),
    .q_stage_o(qst), .q_dur_o(qd),
    .req_mask_o(rm), .sum_mask_o(sm), .prod_mask_o(pm)
  );

  stsc_back u_back (
    .clk_i, .rst_ni, .clear_i(clear),
    .q_valid_i(qv), .q_ready_o(qr), .q_class_i(qc), .q_slot_i(qs),
    .q_stage_i(qst), .q_dur_i(qd),
    .req_mask_i(rm), .sum_mask_i(sm), .prod_mask_i(pm), .busy_o(busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .slot_o(slot), .summed_o(st), .producer_o(pt),
    .effect_o(et), .done_o(done), .count_o(cnt)
  );

  assign m_axis_tdata = {6'd0, cnt, done, et, pt, st, slot, status};

  cfg_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |-> !m_axis_tvalid || busy) else $error("busy flag lost");
  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  bad_cfg_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == StBadConfig) |-> (cnt == '0 && slot == '0))
    else $error("bad config result carries data");

endmodule

FILE: bench/stage_timing_sample_collector_test.sv
// Self-checking testbench for the stage timing sample collector.
`timescale 1ns / 1ps
module stage_timing_sample_collector_test;
  import stsc_pkg::*;

  localparam int unsigned Frames    = 1024;
  localparam int unsigned Stages    = 13;
  localparam int unsigned Envelope  = 12;
  localparam int unsigned StallLimit = 6000;
  localparam int unsigned LongHold  = 300;
  localparam logic [2:0]  RegUnused = 3'd7;

  typedef struct packed {
    logic [3:0]  status;
    logic [9:0]  slot;
    logic [34:0] summed;
    logic [34:0] producer;
    logic [34:0] effect;
    logic [10:0] done;
    logic [31:0] count;
  } report_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = '0;
  logic [63:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [167:0]  m_axis_tdata;

  stage_timing_sample_collector dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // Expected reports in order, and run status.
  report_t     pending_reports[$];
  int unsigned mismatches = 0;
  bit          gapless = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  // Mirror of the collector's configuration and frame store.
  logic [63:0] first_frame_q, warmup_q, window_start_q;
  logic [10:0] measured_q;
  logic [12:0] required_q, summed_sel_q, producer_sel_q;
  logic        config_ok_q;
  logic [12:0] stages_seen[Frames];
  logic [34:0] summed_mem[Frames];
  logic [34:0] producer_mem[Frames];
  logic [34:0] effect_mem[Frames];
  logic [31:0] category_cnt[NumCat];
  logic [10:0] done_q;

  function automatic void clear_run();
    for (int i = 0; i < Frames; i++) begin
      stages_seen[i] = '0;
      summed_mem[i] = '0;
      producer_mem[i] = '0;
      effect_mem[i] = '0;
    end
    for (int i = 0; i < NumCat; i++) category_cnt[i] = '0;
    done_q = '0;
  endfunction

  function automatic void recompute_window();
    logic ok;
    ok = 1'b1;
    if (measured_q == 0 || measured_q > Frames) ok = 1'b0;
    if (required_q == 0) ok = 1'b0;
    if (warmup_q > ~first_frame_q) ok = 1'b0;
    window_start_q = first_frame_q + warmup_q;
    if (ok && ({53'd0, measured_q} - 64'd1) > ~window_start_q) ok = 1'b0;
    config_ok_q = ok;
  endfunction

  function automatic void reset_mirror();
    first_frame_q = '0;
    warmup_q = '0;
    measured_q = 11'd1;
    required_q = 13'h1FFF;
    summed_sel_q = '0;
    producer_sel_q = '0;
    clear_run();
    recompute_window();
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [63:0] data);
    case (idx)
      RegFirstFrame:   first_frame_q = data;
      RegWarmupFrames: warmup_q = {32'd0, data[31:0]};
      RegMeasured:     measured_q = data[10:0];
      RegRequiredMask: required_q = data[12:0];
      RegSummedMask:   summed_sel_q = data[12:0];
      RegProducerMask: producer_sel_q = data[12:0];
      default: return;
    endcase
    clear_run();
    recompute_window();
  endfunction

  function automatic logic [31:0] bump(logic [2:0] cat);
    if (category_cnt[cat] != 32'hFFFF_FFFF) category_cnt[cat]++;
    return category_cnt[cat];
  endfunction

  // Classifies one sample, merges it into the mirrored store, returns the report.
  function automatic report_t predict_sample(logic [63:0] frame, logic [3:0] stage,
                                             logic [31:0] dur);
    report_t     r;
    logic [63:0] off;
    logic [9:0]  ix;
    logic [12:0] bit_m;
    r = '0;
    off = frame - window_start_q;
    ix = off[9:0];
    bit_m = 13'd1 << stage;
    if (!config_ok_q) begin
      r.status = StBadConfig;
    end else if (stage >= Stages) begin
      r.status = StBadStage;
      r.count = bump(CatBadStage);
    end else if (dur[31]) begin
      r.status = StBadDur;
      r.count = bump(CatBadDur);
    end else if (frame < first_frame_q) begin
      r.status = StOutside;
      r.count = bump(CatOutside);
    end else if (frame < window_start_q) begin
      r.status = StWarmup;
      r.count = bump(CatWarmup);
    end else if (off >= {53'd0, measured_q}) begin
      r.status = StOutside;
      r.count = bump(CatOutside);
    end else begin
      r.slot = ix;
      if ((required_q & bit_m) == 0 || (stages_seen[ix] & bit_m) != 0) begin
        if ((required_q & bit_m) == 0) begin
          r.status = StUnrequired;
          r.count = bump(CatUnrequired);
        end else begin
          r.status = StDuplicate;
          r.count = bump(CatDuplicate);
        end
        r.summed = summed_mem[ix];
        r.producer = producer_mem[ix];
        r.effect = effect_mem[ix];
      end else begin
        r.summed = summed_mem[ix];
        r.producer = producer_mem[ix];
        if ((summed_sel_q & required_q & bit_m) != 0) r.summed += {3'd0, dur};
        if ((producer_sel_q & required_q & bit_m) != 0) r.producer += {3'd0, dur};
        // The envelope stage, once seen, stands for the whole frame.
        if (stage == Envelope) r.effect = {3'd0, dur};
        else if (stages_seen[ix][Envelope]) r.effect = effect_mem[ix];
        else r.effect = r.summed;
        stages_seen[ix] |= bit_m;
        summed_mem[ix] = r.summed;
        producer_mem[ix] = r.producer;
        effect_mem[ix] = r.effect;
        if (stages_seen[ix] == required_q) begin
          r.status = StCompleted;
          if (done_q != 11'd2047) done_q++;
        end else begin
          r.status = StAccepted;
        end
      end
    end
    r.done = done_q;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (gapless || p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one sample and waits until it is taken.
  task automatic send_sample(logic [63:0] frame, logic [3:0] stage, logic [31:0] dur);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, dur, stage, frame};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.insert(pending_reports.size(), predict_sample(frame, stage, dur));
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lets every outstanding report drain before touching registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(logic [63:0] first, logic [63:0] warm, logic [63:0] meas,
                            logic [12:0] req, logic [12:0] sm, logic [12:0] pm);
    write_reg(RegFirstFrame, first);
    write_reg(RegWarmupFrames, warm);
    write_reg(RegMeasured, meas);
    write_reg(RegRequiredMask, req);
    write_reg(RegSummedMask, sm);
    write_reg(RegProducerMask, pm);
  endtask

  function automatic logic [31:0] random_duration();
    if ($urandom_range(19) == 0) return {1'b1, 31'($urandom)};
    return {1'b0, 31'($urandom)};
  endfunction

  // Default registers: one frame at id zero, every stage required.
  task automatic test_defaults();
    for (int s = 0; s < Stages; s++) send_sample(64'd0, 4'(s), (s == 5) ? 32'h7FFF_FFFF : 32'(s));
    send_sample(64'd0, 4'd3, 32'd9);
    send_sample(64'd1, 4'd0, 32'd1);
    send_sample(64'd0, 4'd13, 32'd1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0);
    send_sample(64'd0, 4'd2, 32'h8000_0000);
  endtask

  // Bad configurations, ignored index, top-of-range window.
  task automatic test_config_limits();
    write_reg(RegMeasured, 64'd0);
    send_sample(64'd0, 4'd0, 32'd1);
    write_reg(RegMeasured, 64'hFFFF_FFFF_FFFF_F401);
    send_sample(64'd0, 4'd0, 32'd1);
    set_window(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd1, 13'h1FFF, 13'd0, 13'd0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd1);
    set_window(64'hFFFF_FFFF_FFFF_FFFD, 64'd0, 64'd5, 13'h1FFF, 13'd0, 13'd0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFD, 4'd0, 32'd1);
    write_reg(RegRequiredMask, 64'd0);
    send_sample(64'd0, 4'd0, 32'd1);
    set_window(64'hFFFF_FFFF_FFFF_FFFA, 64'd2, 64'd4, 13'h1001, 13'h1FFF, 13'h0001);
    write_reg(RegUnused, 64'd3);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd7);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'd3);
    send_sample(64'hFFFF_FFFF_FFFF_FFFB, 4'd0, 32'd1);
    send_sample(64'hFFFF_FFFF_FFFF_FFF9, 4'd0, 32'd1);
    set_window(64'd0, 64'hFFFF_FFFF, 64'd1024, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    send_sample(64'hFFFF_FFFF + 64'd1023, 4'd4, 32'd5);
    send_sample(64'hFFFF_FFFF + 64'd1024, 4'd4, 32'd5);
  endtask

  // Envelope ordering and unrequired stages with partial sum masks.
  task automatic test_envelope();
    set_window(64'd100, 64'd0, 64'd2, 13'h1007, 13'h0003, 13'h1006);
    send_sample(64'd100, 4'd0, 32'd10);
    send_sample(64'd100, 4'd12, 32'd50);
    send_sample(64'd100, 4'd1, 32'd20);
    send_sample(64'd100, 4'd5, 32'd1);
    send_sample(64'd100, 4'd2, 32'd30);
    send_sample(64'd101, 4'd1, 32'd4);
    send_sample(64'd101, 4'd2, 32'd6);
  endtask

  // Randomized samples in a random window, mostly aimed inside it.
  task automatic test_random(int unsigned count, bit wide, bit quiet, bit hold);
    logic [63:0] first, frame;
    logic [63:0] warm;
    int unsigned meas;
    logic [12:0] req;
    first = {$urandom, $urandom};
    warm = 64'($urandom_range(3));
    meas = wide ? Frames : $urandom_range(8, 2);
    req = 13'($urandom) | 13'h1000;
    if ($urandom_range(1)) req = 13'h1000 | 13'($urandom_range(15));
    set_window(first, warm, 64'(meas), req, 13'($urandom), 13'($urandom));
    gapless = quiet;
    for (int unsigned n = 0; n < count; n++) begin
      if (hold && n == 20) hold_requests++;
      case ($urandom_range(19))
        0: frame = {$urandom, $urandom};
        1: frame = first + 64'($urandom_range(3));
        2: frame = window_start_q + 64'(meas);
        default: frame = window_start_q + 64'($urandom_range(meas - 1));
      endcase
      send_sample(frame, ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13))
                                                : 4'($urandom_range(Stages - 1)),
                  random_duration());
    end
    gapless = 1'b0;
    drain();
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: check each item and stall at random.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    report_t got, want;
    int unsigned p;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tdata[3:0], slot: m_axis_tdata[13:4],
              summed: m_axis_tdata[48:14], producer: m_axis_tdata[83:49],
              effect: m_axis_tdata[118:84], done: m_axis_tdata[129:119],
              count: m_axis_tdata[161:130]};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected item, actual %0h", $time, got);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, got.status);
        check_field("frame_slot", want.slot, got.slot);
        check_field("summed_total", want.summed, got.summed);
        check_field("producer_total", want.producer, got.producer);
        check_field("effect_total", want.effect, got.effect);
        check_field("completed_frames", want.done, got.done);
        check_field("category_count", want.count, got.count);
      end
    end
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      stall_left <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      p = $urandom_range(99);
      m_axis_tready <= gapless || p < 70;
      if (!gapless && p >= 70) begin
        stall_left <= (p >= 97) ? $urandom_range(40, 10) : $urandom_range(2);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    reset_mirror();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_config_limits();
    test_envelope();
    test_random(100, 1'b0, 1'b0, 1'b1);
    test_random(100, 1'b0, 1'b1, 1'b0);
    test_random(100, 1'b1, 1'b0, 1'b0);
    test_random(100, 1'b0, 1'b0, 1'b0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
